// ----- design/gtbt_pkg.sv -----
`timescale 1ns / 1ps

package gtbt_pkg;

    // Coordinate width, 1/1000 mm signed
    localparam int unsigned COORD_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t VAL_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t VAL_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y_HIGH = 3'd6;

    // Record modes; the unused code behaves as MODE_ALL
    localparam logic [1:0] MODE_ALL     = 2'd0;
    localparam logic [1:0] MODE_DEPOSIT = 2'd1;
    localparam logic [1:0] MODE_ZONE    = 2'd2;

    typedef struct packed {
        logic [1:0] record_mode;
        coord_t     z_limit;
        logic       region_enable;
        coord_t     region_x_low;
        coord_t     region_x_high;
        coord_t     region_y_low;
        coord_t     region_y_high;
    } cfg_t;

    // One move after the state-independent decode
    typedef struct packed {
        logic   action;
        logic   position_ok;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t pos_e;
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        logic   in_region;
        logic   above_zone;
        logic   extrudes;
        logic   moves_forward;
    } move_info_t;

    // Update strobes for one axis
    typedef struct packed {
        logic clear;
        logic take_end;
        logic take_start;
    } axis_ctl_t;

    // pos - step, exact in one extra bit, then clamped to the coordinate range
    function automatic coord_t start_point(coord_t pos, coord_t step);
        logic signed [COORD_W:0] diff;
        diff = {pos[COORD_W-1], pos} - {step[COORD_W-1], step};
        if (diff[COORD_W] != diff[COORD_W-1])
            return diff[COORD_W] ? VAL_MIN : VAL_MAX;
        else
            return diff[COORD_W-1:0];
    endfunction

endpackage

// ----- design/gated_toolpath_bounds_tracker_core.sv -----
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// move      move_valid/move_stall   action, position_ok, pos_x..pos_e, step_x..step_e
// bounds    bounds_valid/bounds_stall  x_low..e_top, deposit_started
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One move per cycle while move_stall is low; a taken beat goes to the input register,
// then to the bound registers, which also hold the result on the outputs.
// The bound registers update only when a result leaves its slot, so a stall
// on bounds holds the state and backs up into move_stall.
// Reset clears the bounds to empty, both flags and all configuration to 0.
// cfg_ready is always high; writes are expected while the block is idle.

module gated_toolpath_bounds_tracker_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // move channel
    input  logic                               move_valid,
    output logic                               move_stall,
    input  logic                               action,
    input  logic                               position_ok,
    input  gtbt_pkg::coord_t                   pos_x,
    input  gtbt_pkg::coord_t                   pos_y,
    input  gtbt_pkg::coord_t                   pos_z,
    input  gtbt_pkg::coord_t                   pos_e,
    input  gtbt_pkg::coord_t                   step_x,
    input  gtbt_pkg::coord_t                   step_y,
    input  gtbt_pkg::coord_t                   step_z,
    input  gtbt_pkg::coord_t                   step_e,
    // bounds channel
    output logic                               bounds_valid,
    input  logic                               bounds_stall,
    output gtbt_pkg::coord_t                   x_low,
    output gtbt_pkg::coord_t                   x_top,
    output gtbt_pkg::coord_t                   y_low,
    output gtbt_pkg::coord_t                   y_top,
    output gtbt_pkg::coord_t                   z_low,
    output gtbt_pkg::coord_t                   z_top,
    output gtbt_pkg::coord_t                   e_low,
    output gtbt_pkg::coord_t                   e_top,
    output logic                               deposit_started,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gtbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtbt_pkg::COORD_W-1:0]       cfg_data
);

    gtbt_pkg::cfg_t       cfg_reg;
    gtbt_pkg::move_info_t prep_info;
    gtbt_pkg::move_info_t s1_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 fire;
    logic                 load;
    logic                 started_reg;
    logic                 started_next;
    logic                 ignored_reg;
    logic                 ignored_next;
    logic                 record;
    gtbt_pkg::axis_ctl_t  ctl_xyz;
    gtbt_pkg::axis_ctl_t  ctl_e;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gtbt_pkg::CFG_RECORD_MODE:   cfg_reg.record_mode   <= cfg_data[1:0];
                gtbt_pkg::CFG_Z_LIMIT:       cfg_reg.z_limit       <= cfg_data;
                gtbt_pkg::CFG_REGION_ENABLE: cfg_reg.region_enable <= cfg_data[0];
                gtbt_pkg::CFG_REGION_X_LOW:  cfg_reg.region_x_low  <= cfg_data;
                gtbt_pkg::CFG_REGION_X_HIGH: cfg_reg.region_x_high <= cfg_data;
                gtbt_pkg::CFG_REGION_Y_LOW:  cfg_reg.region_y_low  <= cfg_data;
                gtbt_pkg::CFG_REGION_Y_HIGH: cfg_reg.region_y_high <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // State-independent decode of the incoming beat
    gtbt_move_prep u_prep
    (
        .cfg         (cfg_reg),
        .action      (action),
        .position_ok (position_ok),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .pos_e       (pos_e),
        .step_x      (step_x),
        .step_y      (step_y),
        .step_z      (step_z),
        .step_e      (step_e),
        .info        (prep_info)
    );

    // Pipeline handshake
    assign out_free       = !out_valid_reg || !bounds_stall;
    assign fire           = s1_valid_reg && out_free;
    assign move_stall     = s1_valid_reg && !out_free;
    assign load           = move_valid && !move_stall;
    assign s1_valid_next  = load || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && bounds_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            ignored_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            ignored_reg   <= ignored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_reg <= prep_info;
    end

    // Gating: clear, ignore rectangle, record mode
    always_comb
    begin
        ctl_xyz      = '0;
        ctl_e        = '0;
        started_next = started_reg;
        ignored_next = ignored_reg;
        record       = 1'b0;
        if (fire)
        begin
            if (!s1_reg.action)
            begin
                ctl_xyz.clear = 1'b1;
                ctl_e.clear   = 1'b1;
                started_next  = 1'b0;
                ignored_next  = 1'b0;
            end
            else if (s1_reg.position_ok)
            begin
                ctl_e.take_end = 1'b1;
                if (s1_reg.in_region)
                begin
                    ignored_next = 1'b1;
                end
                else
                begin
                    unique case (cfg_reg.record_mode)
                        gtbt_pkg::MODE_DEPOSIT:
                        begin
                            started_next = started_reg
                                         || (s1_reg.extrudes && s1_reg.moves_forward);
                            record = started_next && s1_reg.extrudes;
                        end
                        gtbt_pkg::MODE_ZONE: record = !s1_reg.above_zone;
                        default:             record = 1'b1;
                    endcase
                    if (record)
                    begin
                        ctl_xyz.take_end   = 1'b1;
                        ctl_xyz.take_start = !ignored_reg;
                        ignored_next       = 1'b0;
                    end
                end
            end
        end
    end

    // Bound registers, which also serve as the result register
    gtbt_axis_bounds u_axis_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_xyz),
        .end_val   (s1_reg.pos_x),
        .start_val (s1_reg.start_x),
        .low       (x_low),
        .top       (x_top)
    );

    gtbt_axis_bounds u_axis_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_xyz),
        .end_val   (s1_reg.pos_y),
        .start_val (s1_reg.start_y),
        .low       (y_low),
        .top       (y_top)
    );

    gtbt_axis_bounds u_axis_z
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_xyz),
        .end_val   (s1_reg.pos_z),
        .start_val (s1_reg.start_z),
        .low       (z_low),
        .top       (z_top)
    );

    // extruder has no start point; take_start stays low
    gtbt_axis_bounds u_axis_e
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_e),
        .end_val   (s1_reg.pos_e),
        .start_val (s1_reg.pos_e),
        .low       (e_low),
        .top       (e_top)
    );

    assign bounds_valid    = out_valid_reg;
    assign deposit_started = started_reg;

    // Bounds hold while a result is stalled
    a_hold_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (bounds_valid && bounds_stall)
        |=> ($stable(x_low) && $stable(z_top) && $stable(e_low) && $stable(deposit_started))
    ) else $error("bounds changed while result stalled");

    // A clear beat leaves empty bounds and no flags
    a_clear_empties: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && !s1_reg.action)
        |=> (x_low == gtbt_pkg::VAL_MAX && x_top == gtbt_pkg::VAL_MIN
             && e_low == gtbt_pkg::VAL_MAX && !deposit_started && !ignored_reg)
    ) else $error("clear beat did not empty the bounds");

    // Bounds are either empty or ordered
    a_bounds_ordered: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((x_low <= x_top) || (x_low == gtbt_pkg::VAL_MAX && x_top == gtbt_pkg::VAL_MIN))
        && ((e_low <= e_top) || (e_low == gtbt_pkg::VAL_MAX && e_top == gtbt_pkg::VAL_MIN))
    ) else $error("bounds out of order");

    // Deposition flag is only raised in deposition mode
    a_started_mode: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(deposit_started) |-> ($past(cfg_reg.record_mode) == gtbt_pkg::MODE_DEPOSIT)
    ) else $error("deposit flag raised outside deposition mode");

endmodule

// ----- design/gtbt_move_prep.sv -----
`timescale 1ns / 1ps

module gtbt_move_prep
(
    input  gtbt_pkg::cfg_t       cfg,
    input  logic                 action,
    input  logic                 position_ok,
    input  gtbt_pkg::coord_t     pos_x,
    input  gtbt_pkg::coord_t     pos_y,
    input  gtbt_pkg::coord_t     pos_z,
    input  gtbt_pkg::coord_t     pos_e,
    input  gtbt_pkg::coord_t     step_x,
    input  gtbt_pkg::coord_t     step_y,
    input  gtbt_pkg::coord_t     step_z,
    input  gtbt_pkg::coord_t     step_e,
    output gtbt_pkg::move_info_t info
);

    logic signed [gtbt_pkg::COORD_W:0] z_start_wide;
    logic signed [gtbt_pkg::COORD_W:0] z_limit_wide;
    logic signed [gtbt_pkg::COORD_W:0] xy_sum;

    // Exact Z start and XY travel, one bit wider than a coordinate
    assign z_start_wide = {pos_z[gtbt_pkg::COORD_W-1], pos_z}
                        - {step_z[gtbt_pkg::COORD_W-1], step_z};
    assign z_limit_wide = {cfg.z_limit[gtbt_pkg::COORD_W-1], cfg.z_limit};
    assign xy_sum       = {step_x[gtbt_pkg::COORD_W-1], step_x}
                        + {step_y[gtbt_pkg::COORD_W-1], step_y};

    always_comb
    begin
        info.action        = action;
        info.position_ok   = position_ok;
        info.pos_x         = pos_x;
        info.pos_y         = pos_y;
        info.pos_z         = pos_z;
        info.pos_e         = pos_e;
        info.start_x       = gtbt_pkg::start_point(pos_x, step_x);
        info.start_y       = gtbt_pkg::start_point(pos_y, step_y);
        info.start_z       = gtbt_pkg::start_point(pos_z, step_z);
        // ignore rectangle, inclusive on all edges
        info.in_region     = cfg.region_enable
                           && (pos_x >= cfg.region_x_low) && (pos_x <= cfg.region_x_high)
                           && (pos_y >= cfg.region_y_low) && (pos_y <= cfg.region_y_high);
        // both ends of the move above the zone
        info.above_zone    = (pos_z > cfg.z_limit) && (z_start_wide > z_limit_wide);
        info.extrudes      = (step_e > 0);
        info.moves_forward = (xy_sum > 0);
    end

endmodule

// ----- design/gtbt_axis_bounds.sv -----
`timescale 1ns / 1ps

module gtbt_axis_bounds
(
    input  logic                clk,
    input  logic                rst_n,
    input  gtbt_pkg::axis_ctl_t ctl,
    input  gtbt_pkg::coord_t    end_val,
    input  gtbt_pkg::coord_t    start_val,
    output gtbt_pkg::coord_t    low,
    output gtbt_pkg::coord_t    top
);

    gtbt_pkg::coord_t min_reg;
    gtbt_pkg::coord_t min_next;
    gtbt_pkg::coord_t max_reg;
    gtbt_pkg::coord_t max_next;
    gtbt_pkg::coord_t min_mid;
    gtbt_pkg::coord_t max_mid;

    // Fold in the end point, then the start point
    always_comb
    begin
        min_mid = (ctl.take_end && (end_val < min_reg)) ? end_val : min_reg;
        max_mid = (ctl.take_end && (end_val > max_reg)) ? end_val : max_reg;
        min_next = (ctl.take_start && (start_val < min_mid)) ? start_val : min_mid;
        max_next = (ctl.take_start && (start_val > max_mid)) ? start_val : max_mid;
        if (ctl.clear)
        begin
            min_next = gtbt_pkg::VAL_MAX;
            max_next = gtbt_pkg::VAL_MIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= gtbt_pkg::VAL_MAX;
            max_reg <= gtbt_pkg::VAL_MIN;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign low = min_reg;
    assign top = max_reg;

endmodule

// ----- bench/gated_toolpath_bounds_tracker_core_tb.sv -----
`timescale 1ns / 1ps

module gated_toolpath_bounds_tracker_core_tb;

    import gtbt_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as MODE_ALL
    localparam int PHASES        = 8;
    localparam int PHASE_MOVES   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_CAP    = 100;
    localparam coord_t JUNK      = 32'h5AA5_C33C;

    typedef struct packed {
        logic   action;
        logic   position_ok;
        coord_t pos_x, pos_y, pos_z, pos_e;
        coord_t step_x, step_y, step_z, step_e;
    } move_t;

    typedef struct packed {
        coord_t x_low, x_top, y_low, y_top, z_low, z_top, e_low, e_top;
        logic   deposit_started;
    } bounds_t;

    // one line of the directed script: a register write or a move beat
    typedef struct {
        bit                     is_cfg;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [COORD_W-1:0]     reg_val;
        move_t                  mv;
        bit                     pinned;
        bounds_t                pin;
    } row_t;

    localparam bounds_t NO_BOUNDS = '{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
                                      VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 1'b0};

    // DUT ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   move_valid = 1'b0;
    logic                   move_stall;
    logic                   action = 1'b1;
    logic                   position_ok = 1'b0;
    coord_t                 pos_x = '0, pos_y = '0, pos_z = '0, pos_e = '0;
    coord_t                 step_x = '0, step_y = '0, step_z = '0, step_e = '0;
    logic                   bounds_valid;
    logic                   bounds_stall = 1'b0;
    coord_t                 x_low, x_top, y_low, y_top, z_low, z_top, e_low, e_top;
    logic                   deposit_started;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;

    // sideband carried with each move beat: a hand-typed expectation
    bit                     pin_on = 1'b0;
    bounds_t                pin_box = NO_BOUNDS;

    // tracker state and register copy
    bounds_t                box_st = NO_BOUNDS;
    bit                     gap_pending = 1'b0;
    logic [1:0]             mode_reg = MODE_ALL;
    coord_t                 zlim_reg = '0;
    logic                   win_on = 1'b0;
    coord_t                 win_xl = '0, win_xh = '0, win_yl = '0, win_yh = '0;

    bounds_t                bounds_due[$];
    row_t                   script[$];
    int                     errors = 0;
    bit                     calm = 1'b0;

    gated_toolpath_bounds_tracker_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- tracker

    function automatic void widen(inout coord_t lo, inout coord_t hi, input coord_t v);
        if (v < lo)
            lo = v;
        if (v > hi)
            hi = v;
    endfunction

    // start point of a move, exact difference clamped to 32-bit signed
    function automatic coord_t back_point(coord_t p, coord_t d);
        longint diff;
        diff = longint'(p) - longint'(d);
        if (diff > longint'(VAL_MAX))
            return VAL_MAX;
        if (diff < longint'(VAL_MIN))
            return VAL_MIN;
        return coord_t'(diff);
    endfunction

    function automatic bounds_t track_move(move_t m);
        longint z_back;
        bit     take;
        z_back = longint'(m.pos_z) - longint'(m.step_z);
        if (!m.action)
        begin
            box_st = NO_BOUNDS;
            gap_pending = 1'b0;
        end
        else if (m.position_ok)
        begin
            widen(box_st.e_low, box_st.e_top, m.pos_e);
            if (win_on && m.pos_x >= win_xl && m.pos_x <= win_xh &&
                m.pos_y >= win_yl && m.pos_y <= win_yh)
                gap_pending = 1'b1;
            else
            begin
                take = 1'b1;
                case (mode_reg)
                    MODE_DEPOSIT:
                    begin
                        if (m.step_e > 0 && longint'(m.step_x) + longint'(m.step_y) > 0)
                            box_st.deposit_started = 1'b1;
                        take = box_st.deposit_started && m.step_e > 0;
                    end
                    MODE_ZONE:
                        take = !(m.pos_z > zlim_reg && z_back > longint'(zlim_reg));
                    default: ;
                endcase
                if (take)
                begin
                    widen(box_st.x_low, box_st.x_top, m.pos_x);
                    widen(box_st.y_low, box_st.y_top, m.pos_y);
                    widen(box_st.z_low, box_st.z_top, m.pos_z);
                    // start point only joins when no ignored move came in between
                    if (!gap_pending)
                    begin
                        widen(box_st.x_low, box_st.x_top, back_point(m.pos_x, m.step_x));
                        widen(box_st.y_low, box_st.y_top, back_point(m.pos_y, m.step_y));
                        widen(box_st.z_low, box_st.z_top, back_point(m.pos_z, m.step_z));
                    end
                    gap_pending = 1'b0;
                end
            end
        end
        return box_st;
    endfunction

    function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        case (idx)
            CFG_RECORD_MODE:   mode_reg = val[1:0];
            CFG_Z_LIMIT:       zlim_reg = val;
            CFG_REGION_ENABLE: win_on = val[0];
            CFG_REGION_X_LOW:  win_xl = val;
            CFG_REGION_X_HIGH: win_xh = val;
            CFG_REGION_Y_LOW:  win_yl = val;
            CFG_REGION_Y_HIGH: win_yh = val;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    // sample beats on the edge; payload and stalls are pre-edge values here
    always @(posedge clk)
    begin : watch
        bounds_t want;
        bounds_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                set_reg(cfg_index, cfg_data);
            if (move_valid && !move_stall)
            begin
                want = track_move({action, position_ok, pos_x, pos_y, pos_z, pos_e,
                                   step_x, step_y, step_z, step_e});
                bounds_due.push_back(pin_on ? pin_box : want);
            end
            if (bounds_valid && !bounds_stall)
            begin
                got = {x_low, x_top, y_low, y_top, z_low, z_top, e_low, e_top,
                       deposit_started};
                if (bounds_due.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $error("bounds beat with nothing expected");
                end
                else
                begin
                    want = bounds_due.pop_front();
                    check_field("x_low", want.x_low, got.x_low);
                    check_field("x_top", want.x_top, got.x_top);
                    check_field("y_low", want.y_low, got.y_low);
                    check_field("y_top", want.y_top, got.y_top);
                    check_field("z_low", want.z_low, got.z_low);
                    check_field("z_top", want.z_top, got.z_top);
                    check_field("e_low", want.e_low, got.e_low);
                    check_field("e_top", want.e_top, got.e_top);
                    check_field("deposit_started", 32'(want.deposit_started),
                                32'(got.deposit_started));
                end
            end
        end
    end

    // receiver back-pressure, off during the calm phase
    always @(posedge clk)
        bounds_stall <= !calm && ($urandom_range(0, 99) < 12);

    // ---------------------------------------------------------------- driving

    task automatic send_move(move_t m, bit pinned, bounds_t pin);
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            move_valid <= 1'b0;
            @(posedge clk);
            while (!calm && $urandom_range(0, 99) < 12)
                @(posedge clk);
        end
        {action, position_ok, pos_x, pos_y, pos_z, pos_e,
         step_x, step_y, step_z, step_e} <= m;
        pin_on     <= pinned;
        pin_box    <= pin;
        move_valid <= 1'b1;
        do
            @(posedge clk);
        while (move_stall);
    endtask

    // drop valid and wait until every bounds beat is back
    task automatic settle();
        move_valid <= 1'b0;
        @(posedge clk);
        while (bounds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic coord_t pick_coord(int span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return coord_t'($urandom);
        if (r < 12)
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        return coord_t'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic bounds_t bounds_of(coord_t xl, coord_t xt, coord_t yl, coord_t yt,
                                          coord_t zl, coord_t zt, coord_t el, coord_t et,
                                          logic st);
        return {xl, xt, yl, yt, zl, zt, el, et, st};
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        row_t r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.pinned  = 1'b0;
        script.push_back(r);
    endfunction

    function automatic void add_move(logic a, logic ok, coord_t px, coord_t py, coord_t pz,
                                     coord_t pe, coord_t sx, coord_t sy, coord_t sz,
                                     coord_t se);
        row_t r;
        r.is_cfg = 1'b0;
        r.mv     = {a, ok, px, py, pz, pe, sx, sy, sz, se};
        r.pinned = 1'b0;
        r.pin    = NO_BOUNDS;
        script.push_back(r);
    endfunction

    function automatic void pin_last(bounds_t b);
        script[script.size() - 1].pinned = 1'b1;
        script[script.size() - 1].pin    = b;
    endfunction

    // ---------------------------------------------------------------- stimulus

    initial
    begin : stimulus
        int          ph;
        int unsigned r;
        move_t       m;
        int          nx, ny, nz, de;
        int          cur_x, cur_y, cur_z, cur_e;

        cur_x = 0;
        cur_y = 0;
        cur_z = 0;
        cur_e = 0;

        // empty bounds, zero move, extremes with clamped start points, clear
        add_move(1, 0, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK);
        pin_last(NO_BOUNDS);
        add_move(1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        pin_last(bounds_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        add_move(1, 1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        pin_last(bounds_of(0, VAL_MAX, 0, VAL_MAX, 0, VAL_MAX, 0, VAL_MAX, 1'b0));
        add_move(1, 1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        pin_last(bounds_of(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
                           VAL_MIN, VAL_MAX, 1'b0));
        add_move(0, 1, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK);
        pin_last(NO_BOUNDS);

        // deposition: XY sum of zero does not start, wide sum starts without wrap
        add_cfg(CFG_RECORD_MODE, MODE_DEPOSIT);
        add_move(1, 1, 100, 100, 0, 10, 5, -5, 0, 10);
        add_move(1, 1, 200, 200, 0, 20, VAL_MAX, 1, 0, 1);
        add_move(1, 1, 300, 300, 0, 20, 10, 10, 0, 0);
        add_move(1, 1, 250, 250, 0, 21, -10, -10, 0, 1);
        add_move(0, 0, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK);
        pin_last(NO_BOUNDS);

        // low-Z zone: both ends above, start at limit, start far off the range
        add_cfg(CFG_RECORD_MODE, MODE_ZONE);
        add_cfg(CFG_Z_LIMIT, 100);
        add_move(1, 1, 0, 0, 200, 5, 0, 0, 50, 1);
        add_move(1, 1, 0, 0, 200, 5, 0, 0, 100, 1);
        add_move(1, 1, 0, 0, VAL_MAX, 5, 0, 0, VAL_MIN, 1);
        add_cfg(CFG_Z_LIMIT, VAL_MIN);
        add_move(1, 1, 7, 7, VAL_MIN, 5, 1, 1, 0, 1);

        // ignore rectangle: inside, on the edge, first move after, then normal
        add_cfg(CFG_RECORD_MODE, MODE_SPARE);
        add_cfg(CFG_REGION_X_LOW, 10);
        add_cfg(CFG_REGION_X_HIGH, 20);
        add_cfg(CFG_REGION_Y_LOW, 10);
        add_cfg(CFG_REGION_Y_HIGH, 20);
        add_cfg(CFG_REGION_ENABLE, 1);
        add_move(1, 1, 15, 15, 0, 6, 1, 1, 0, 1);
        add_move(1, 1, 10, 20, 0, 6, 1, 1, 0, 1);
        add_move(1, 1, 21, 15, 2, 6, 11, 0, 2, 1);
        add_move(1, 1, 30, 30, 3, 6, 9, 15, 3, 0);

        // inverted rectangle holds nothing; full-range rectangle holds all
        add_cfg(CFG_REGION_X_LOW, 20);
        add_cfg(CFG_REGION_X_HIGH, 10);
        add_move(1, 1, 15, 15, 0, 6, 1, 1, 0, 1);
        add_cfg(CFG_REGION_X_LOW, VAL_MIN);
        add_cfg(CFG_REGION_X_HIGH, VAL_MAX);
        add_cfg(CFG_REGION_Y_LOW, VAL_MIN);
        add_cfg(CFG_REGION_Y_HIGH, VAL_MAX);
        add_move(1, 1, VAL_MIN, VAL_MAX, 0, 6, 1, 1, 0, 1);
        add_move(1, 1, 0, 0, 0, 7, 0, 0, 0, 1);
        add_move(0, 1, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK, JUNK);
        pin_last(NO_BOUNDS);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            if (script[i].is_cfg)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send_move(script[i].mv, script[i].pinned, script[i].pin);

        // random phases, each under a fresh register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            calm = (ph == 3);
            write_reg(CFG_RECORD_MODE, 32'($urandom_range(0, 3)));
            write_reg(CFG_Z_LIMIT, (ph == 5) ? VAL_MAX : (ph == 6) ? VAL_MIN
                                                       : pick_coord(1000));
            write_reg(CFG_REGION_ENABLE, 32'($urandom_range(0, 1)));
            write_reg(CFG_REGION_X_LOW, pick_coord(4000));
            write_reg(CFG_REGION_X_HIGH, pick_coord(4000));
            write_reg(CFG_REGION_Y_LOW, pick_coord(4000));
            write_reg(CFG_REGION_Y_HIGH, pick_coord(4000));

            repeat (PHASE_MOVES)
            begin
                r = $urandom_range(0, 99);
                m = {1'b1, 1'b1, pick_coord(4000), pick_coord(4000), pick_coord(1000),
                     pick_coord(4000), pick_coord(400), pick_coord(400), pick_coord(400),
                     pick_coord(200)};
                if (r < 3)
                    m.action = 1'b0;
                else if (r < 8)
                    m.position_ok = 1'b0;
                else if (r >= 18)
                begin
                    // coherent toolpath move: step is the distance from the last point
                    nx = ($urandom_range(0, 1) != 0) ? cur_x + int'($urandom_range(0, 800)) - 400
                                                     : int'($urandom_range(0, 8800)) - 4400;
                    ny = ($urandom_range(0, 1) != 0) ? cur_y + int'($urandom_range(0, 800)) - 400
                                                     : int'($urandom_range(0, 8800)) - 4400;
                    nz = ($urandom_range(0, 4) != 0) ? cur_z
                                                     : int'($urandom_range(0, 2000)) - 1000;
                    de = ($urandom_range(0, 3) != 0) ? int'($urandom_range(1, 200))
                                                     : -int'($urandom_range(0, 50));
                    m.pos_x  = nx;
                    m.pos_y  = ny;
                    m.pos_z  = nz;
                    m.pos_e  = cur_e + de;
                    m.step_x = nx - cur_x;
                    m.step_y = ny - cur_y;
                    m.step_z = nz - cur_z;
                    m.step_e = de;
                    if ($urandom_range(0, 9) == 0)
                        m.step_z = pick_coord(1000);
                    cur_x = nx;
                    cur_y = ny;
                    cur_z = nz;
                    cur_e = cur_e + de;
                end
                send_move(m, 1'b0, NO_BOUNDS);
            end
        end

        calm = 1'b0;
        settle();
        if (errors == 0 && bounds_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
